// ----- hdl/assert_macros.svh -----
// Assertion macros shared by the RTL modules of the restriction block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that PROP holds at every rising edge of CLK while reset is released.
`define ASSERT_PROP(LBL, CLK, RST_N, PROP, MSG) \
    LBL: assert property (@(posedge CLK) disable iff (!RST_N) PROP) \
        else $error(MSG);

// Checks that the condition COND never holds at a rising edge of CLK outside reset.
`define ASSERT_NEVER(LBL, CLK, RST_N, COND, MSG) \
    LBL: assert property (@(posedge CLK) disable iff (!RST_N) !(COND)) \
        else $error(MSG);

`endif

// ----- hdl/mfwr_pkg.sv -----
// Shared types and constants of the 3D full-weighting restriction block.
`default_nettype none

package mfwr_pkg;

    localparam int SAMPLE_W   = 32;
    localparam int POINT_W    = 12;
    localparam int FINE_IN_W  = 5;
    localparam int LINE_W     = 4;
    localparam int PLANE_W    = 8;
    localparam int CFG_DATA_W = 8;
    localparam int IN_TDATA_W = 64;
    localparam int AVG_SHIFT  = 6;
    localparam int ACC_W      = SAMPLE_W + AVG_SHIFT;
    localparam int QUEUE_DEPTH = 2;

    // Input item opcodes.
    localparam logic OP_WRITE   = 1'b0;
    localparam logic OP_COMPUTE = 1'b1;

    // Result status codes.
    localparam logic STATUS_OK  = 1'b0;
    localparam logic STATUS_ERR = 1'b1;

    // Configuration register indexes.
    typedef logic t_reg_index;
    localparam t_reg_index REG_LINE_LEN   = 1'b0;
    localparam t_reg_index REG_PLANE_SIZE = 1'b1;

    // Command kinds handed from the front end to the back end.
    typedef logic [1:0] t_kind;
    localparam t_kind KIND_WRITE   = 2'd0;
    localparam t_kind KIND_COMPUTE = 2'd1;
    localparam t_kind KIND_ERROR   = 2'd2;

    typedef struct packed {
        logic [LINE_W-1:0]  line_len;
        logic [PLANE_W-1:0] plane_size;
    } t_cfg;

endpackage

`default_nettype wire

// ----- hdl/multigrid_full_weighting_restrict_3d.sv -----
// Top level of the 3D 27-point full-weighting restriction block.
//
// The block keeps a cubic fine grid of FINE_DIM^3 signed 32-bit fixed-point
// samples in an internal memory whose contents are undefined until written,
// so every sample that a compute request touches must be loaded first. A
// write request (tuser 0) stores one sample; writes with a coordinate at or
// beyond FINE_DIM are dropped and no write request produces a result. A
// compute request (tuser 1) names a 1-based coarse point number, which the
// front end splits into coarse coordinates with a shared radix-2 divider:
// 12 steps by plane_size, then 8 steps by line_len. The back end then reads
// the 27 fine samples around (2i, 2j, 2k) one per cycle from the single
// memory read port, accumulates them with weights 8/4/2/1 exactly and
// returns the sum shifted right arithmetically by 6 (rounding toward minus
// infinity) with status 0. Point number zero, a zero register, or a center
// whose stencil would leave the grid returns value 0 with status 1. A queue
// of two commands sits between front end and back end, so the divider works
// on the next request while the stencil of the previous one is read. A
// compute request occupies the back end for its 27 memory reads plus
// pipeline fill and result hand-off and the front end for its divider
// steps, so back-to-back compute requests are paced by the memory read
// port. The result register lets write requests proceed while a finished
// result waits on m_axis_tready; compute and error requests wait until it
// is free. Configuration registers are written through the cfg channel,
// which is always ready, and must only be changed while no request is in
// flight.
`default_nettype none

module multigrid_full_weighting_restrict_3d
    import mfwr_pkg::*;
#(
    parameter int FINE_DIM = 32
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    // Configuration write channel.
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  t_reg_index              i_cfg_index,
    input  logic [CFG_DATA_W-1:0]   i_cfg_data,
    // Request stream.
    input  logic                    s_axis_tvalid,
    output logic                    s_axis_tready,
    // fine_x[4:0], fine_y[9:5], fine_z[14:10], sample[46:15],
    // point_number[58:47], zero fill[63:59]
    input  logic [IN_TDATA_W-1:0]   s_axis_tdata,
    // opcode[0]
    input  logic                    s_axis_tuser,
    // Result stream.
    output logic                    m_axis_tvalid,
    input  logic                    m_axis_tready,
    // coarse_value[31:0]
    output logic [SAMPLE_W-1:0]     m_axis_tdata,
    // status[0]
    output logic                    m_axis_tuser
);

    localparam int CW = $clog2(FINE_DIM);
    // Queue entry: kind, x, y, z, sample from the top bit down.
    localparam int QW = $bits(t_kind) + 3 * CW + SAMPLE_W;

    logic [LINE_W-1:0]   r_line_len;
    logic [PLANE_W-1:0]  r_plane_size;
    t_cfg                cfg;

    // Fields of the incoming request.
    logic                req_opcode;
    logic [FINE_IN_W-1:0] req_fine_x;
    logic [FINE_IN_W-1:0] req_fine_y;
    logic [FINE_IN_W-1:0] req_fine_z;
    logic [SAMPLE_W-1:0] req_sample;
    logic [POINT_W-1:0]  req_point_number;

    // Front end to queue.
    logic                f_valid;
    logic                f_ready;
    t_kind               f_kind;
    logic [CW-1:0]       f_x;
    logic [CW-1:0]       f_y;
    logic [CW-1:0]       f_z;
    logic [SAMPLE_W-1:0] f_sample;
    logic [QW-1:0]       q_push_data;

    // Queue to back end.
    logic                q_valid;
    logic                q_ready;
    logic [QW-1:0]       q_pop_data;
    t_kind               b_kind;
    logic [CW-1:0]       b_x;
    logic [CW-1:0]       b_y;
    logic [CW-1:0]       b_z;
    logic [SAMPLE_W-1:0] b_sample;

    // Configuration registers; the write channel never stalls.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_len   <= LINE_W'(15);
            r_plane_size <= PLANE_W'(225);
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_LINE_LEN:   r_line_len   <= i_cfg_data[LINE_W-1:0];
                REG_PLANE_SIZE: r_plane_size <= i_cfg_data[PLANE_W-1:0];
            endcase
        end
    end

    assign cfg.line_len   = r_line_len;
    assign cfg.plane_size = r_plane_size;

    assign req_opcode       = s_axis_tuser;
    assign req_fine_x       = s_axis_tdata[4:0];
    assign req_fine_y       = s_axis_tdata[9:5];
    assign req_fine_z       = s_axis_tdata[14:10];
    assign req_sample       = s_axis_tdata[46:15];
    assign req_point_number = s_axis_tdata[58:47];

    mfwr_front #(
        .FINE_DIM (FINE_DIM)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (cfg),
        .i_valid        (s_axis_tvalid),
        .o_ready        (s_axis_tready),
        .i_opcode       (req_opcode),
        .i_fine_x       (req_fine_x),
        .i_fine_y       (req_fine_y),
        .i_fine_z       (req_fine_z),
        .i_sample       (req_sample),
        .i_point_number (req_point_number),
        .o_push_valid   (f_valid),
        .i_push_ready   (f_ready),
        .o_kind         (f_kind),
        .o_x            (f_x),
        .o_y            (f_y),
        .o_z            (f_z),
        .o_sample       (f_sample)
    );

    assign q_push_data = {f_kind, f_x, f_y, f_z, f_sample};

    mfwr_queue #(
        .WIDTH (QW),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (f_valid),
        .o_push_ready (f_ready),
        .i_push_data  (q_push_data),
        .o_pop_valid  (q_valid),
        .i_pop_ready  (q_ready),
        .o_pop_data   (q_pop_data)
    );

    assign b_kind   = q_pop_data[QW-1 -: $bits(t_kind)];
    assign b_x      = q_pop_data[SAMPLE_W + 3 * CW - 1 -: CW];
    assign b_y      = q_pop_data[SAMPLE_W + 2 * CW - 1 -: CW];
    assign b_z      = q_pop_data[SAMPLE_W + CW - 1 -: CW];
    assign b_sample = q_pop_data[SAMPLE_W-1:0];

    mfwr_back #(
        .FINE_DIM (FINE_DIM)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (q_valid),
        .o_cmd_ready (q_ready),
        .i_kind      (b_kind),
        .i_x         (b_x),
        .i_y         (b_y),
        .i_z         (b_z),
        .i_sample    (b_sample),
        .o_valid     (m_axis_tvalid),
        .i_ready     (m_axis_tready),
        .o_value     (m_axis_tdata),
        .o_status    (m_axis_tuser)
    );

endmodule

`default_nettype wire

// ----- hdl/mfwr_front.sv -----
// Front end: accepts requests, splits the point number into coordinates.
`default_nettype none
`include "assert_macros.svh"

module mfwr_front
    import mfwr_pkg::*;
#(
    parameter int FINE_DIM = 32,
    localparam int CW = $clog2(FINE_DIM)
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cfg                  i_cfg,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic                  i_opcode,
    input  logic [FINE_IN_W-1:0]  i_fine_x,
    input  logic [FINE_IN_W-1:0]  i_fine_y,
    input  logic [FINE_IN_W-1:0]  i_fine_z,
    input  logic [SAMPLE_W-1:0]   i_sample,
    input  logic [POINT_W-1:0]    i_point_number,
    output logic                  o_push_valid,
    input  logic                  i_push_ready,
    output t_kind                 o_kind,
    output logic [CW-1:0]         o_x,
    output logic [CW-1:0]         o_y,
    output logic [CW-1:0]         o_z,
    output logic [SAMPLE_W-1:0]   o_sample
);

    localparam int CNT_W = $clog2(POINT_W + 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_PUSH = 2'd2;

    localparam logic PHASE_PLANE = 1'b0;
    localparam logic PHASE_LINE  = 1'b1;

    logic [1:0]          r_state, n_state;
    t_kind               r_kind, n_kind;
    logic [CW-1:0]       r_x, n_x;
    logic [CW-1:0]       r_y, n_y;
    logic [CW-1:0]       r_z, n_z;
    logic [SAMPLE_W-1:0] r_sample, n_sample;
    logic [POINT_W-1:0]  r_quo, n_quo;
    logic [PLANE_W-1:0]  r_rem, n_rem;
    logic [PLANE_W-1:0]  r_div, n_div;
    logic [CNT_W-1:0]    r_cnt, n_cnt;
    logic                r_phase, n_phase;

    logic [PLANE_W:0]    div_shift;
    logic [PLANE_W:0]    div_sub;
    logic                div_bit;
    logic [PLANE_W-1:0]  div_rem;
    logic [POINT_W-1:0]  q_full;
    logic [POINT_W+1:0]  k_center;
    logic [PLANE_W+1:0]  j_center;
    logic [PLANE_W+1:0]  i_center;
    logic                in_grid;

    // One restoring division step per cycle; the dividend shifts out of the
    // top of r_quo while quotient bits shift in at the bottom.
    always_comb begin
        div_shift = {r_rem, r_quo[POINT_W-1]};
        div_sub   = div_shift - {1'b0, r_div};
        div_bit   = (div_shift >= {1'b0, r_div});
        div_rem   = div_bit ? div_sub[PLANE_W-1:0] : div_shift[PLANE_W-1:0];
        q_full    = {r_quo[POINT_W-2:0], div_bit};
        // Fine centers are twice the 1-based coarse coordinates.
        k_center  = {1'b0, q_full, 1'b0} + (POINT_W + 2)'(2);
        j_center  = {1'b0, q_full[PLANE_W-1:0], 1'b0} + (PLANE_W + 2)'(2);
        i_center  = {1'b0, div_rem, 1'b0} + (PLANE_W + 2)'(2);
        in_grid   = (int'(i_fine_x) < FINE_DIM) && (int'(i_fine_y) < FINE_DIM)
                    && (int'(i_fine_z) < FINE_DIM);
    end

    always_comb begin
        n_state  = r_state;
        n_kind   = r_kind;
        n_x      = r_x;
        n_y      = r_y;
        n_z      = r_z;
        n_sample = r_sample;
        n_quo    = r_quo;
        n_rem    = r_rem;
        n_div    = r_div;
        n_cnt    = r_cnt;
        n_phase  = r_phase;
        unique case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    n_sample = i_sample;
                    if (i_opcode == OP_WRITE) begin
                        n_kind = KIND_WRITE;
                        n_x    = CW'(i_fine_x);
                        n_y    = CW'(i_fine_y);
                        n_z    = CW'(i_fine_z);
                        // Writes outside the grid are dropped here.
                        n_state = in_grid ? ST_PUSH : ST_IDLE;
                    end else if ((i_point_number == '0) || (i_cfg.line_len == '0)
                                 || (i_cfg.plane_size == '0)) begin
                        n_kind  = KIND_ERROR;
                        n_state = ST_PUSH;
                    end else begin
                        n_kind  = KIND_COMPUTE;
                        n_quo   = i_point_number - 1'b1;
                        n_rem   = '0;
                        n_div   = i_cfg.plane_size;
                        n_cnt   = CNT_W'(POINT_W);
                        n_phase = PHASE_PLANE;
                        n_state = ST_DIV;
                    end
                end
            end
            ST_DIV: begin
                n_quo = q_full;
                n_rem = div_rem;
                n_cnt = r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    if (r_phase == PHASE_PLANE) begin
                        if (int'(k_center) >= FINE_DIM - 1) begin
                            n_kind  = KIND_ERROR;
                            n_state = ST_PUSH;
                        end else begin
                            // Second pass splits the remainder by the line length.
                            n_z     = CW'(k_center);
                            n_quo   = {div_rem, {(POINT_W - PLANE_W){1'b0}}};
                            n_rem   = '0;
                            n_div   = PLANE_W'(i_cfg.line_len);
                            n_cnt   = CNT_W'(PLANE_W);
                            n_phase = PHASE_LINE;
                        end
                    end else begin
                        if ((int'(j_center) >= FINE_DIM - 1)
                            || (int'(i_center) >= FINE_DIM - 1)) begin
                            n_kind = KIND_ERROR;
                        end else begin
                            n_y = CW'(j_center);
                            n_x = CW'(i_center);
                        end
                        n_state = ST_PUSH;
                    end
                end
            end
            ST_PUSH: begin
                if (i_push_ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind   <= n_kind;
        r_x      <= n_x;
        r_y      <= n_y;
        r_z      <= n_z;
        r_sample <= n_sample;
        r_quo    <= n_quo;
        r_rem    <= n_rem;
        r_div    <= n_div;
        r_cnt    <= n_cnt;
        r_phase  <= n_phase;
    end

    assign o_ready      = (r_state == ST_IDLE);
    assign o_push_valid = (r_state == ST_PUSH);
    assign o_kind       = r_kind;
    assign o_x          = r_x;
    assign o_y          = r_y;
    assign o_z          = r_z;
    assign o_sample     = r_sample;

    `ASSERT_PROP(a_div_count_live, i_clk, i_rst_n,
        (r_state == ST_DIV) |-> (r_cnt != '0),
        "divider running with an exhausted step count")

endmodule

`default_nettype wire

// ----- hdl/mfwr_queue.sv -----
// Short command queue between the front end and the back end.
`default_nettype none
`include "assert_macros.svh"

module mfwr_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push_valid,
    output logic             o_push_ready,
    input  logic [WIDTH-1:0] i_push_data,
    output logic             o_pop_valid,
    input  logic             i_pop_ready,
    output logic [WIDTH-1:0] o_pop_data
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_slot [DEPTH];
    logic [PW-1:0]    r_wr, n_wr;
    logic [PW-1:0]    r_rd, n_rd;
    logic [NW-1:0]    r_count, n_count;
    logic             push;
    logic             pop;

    assign o_push_ready = (int'(r_count) < DEPTH);
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_data   = r_slot[r_rd];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count;
        if (push) begin
            n_wr = (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (pop) begin
            n_rd = (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        if (push && !pop) begin
            n_count = r_count + 1'b1;
        end else if (pop && !push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_slot[r_wr] <= i_push_data;
        end
    end

    `ASSERT_PROP(a_count_bound, i_clk, i_rst_n,
        int'(r_count) <= DEPTH,
        "queue fill count above its depth")
    `ASSERT_PROP(a_count_grows, i_clk, i_rst_n,
        (push && !pop) |=> (r_count == $past(r_count) + 1'b1),
        "queue fill count did not follow a lone push")

endmodule

`default_nettype wire

// ----- hdl/mfwr_back.sv -----
// Back end: fine-grid memory, 27-tap stencil sequencer and result register.
`default_nettype none
`include "assert_macros.svh"

module mfwr_back
    import mfwr_pkg::*;
#(
    parameter int FINE_DIM = 32,
    localparam int CW = $clog2(FINE_DIM)
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cmd_valid,
    output logic                o_cmd_ready,
    input  t_kind               i_kind,
    input  logic [CW-1:0]       i_x,
    input  logic [CW-1:0]       i_y,
    input  logic [CW-1:0]       i_z,
    input  logic [SAMPLE_W-1:0] i_sample,
    output logic                o_valid,
    input  logic                i_ready,
    output logic [SAMPLE_W-1:0] o_value,
    output logic                o_status
);

    localparam int DEPTH = FINE_DIM * FINE_DIM * FINE_DIM;
    localparam int AW    = $clog2(DEPTH);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_RUN   = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;
    localparam logic [1:0] ST_OUT   = 2'd3;

    localparam logic [1:0] TAP_LO  = 2'd0;
    localparam logic [1:0] TAP_MID = 2'd1;
    localparam logic [1:0] TAP_HI  = 2'd2;
    localparam logic [1:0] SH_CENTER = 2'd3;

    function automatic logic [AW-1:0] cell_addr(input logic [CW-1:0] x,
                                                input logic [CW-1:0] y,
                                                input logic [CW-1:0] z);
        cell_addr = AW'(x) * AW'(FINE_DIM * FINE_DIM) + AW'(y) * AW'(FINE_DIM) + AW'(z);
    endfunction

    logic [1:0]                 r_state, n_state;
    logic [CW-1:0]              r_cx, n_cx;
    logic [CW-1:0]              r_cy, n_cy;
    logic [CW-1:0]              r_cz, n_cz;
    logic [1:0]                 r_dx, n_dx;
    logic [1:0]                 r_dy, n_dy;
    logic [1:0]                 r_dz, n_dz;
    logic                       r_rd_valid, n_rd_valid;
    logic [1:0]                 r_rd_sh, n_rd_sh;
    logic signed [ACC_W-1:0]    r_acc, n_acc;
    logic                       r_out_valid, n_out_valid;
    logic [SAMPLE_W-1:0]        r_out_value, n_out_value;
    logic                       r_out_status, n_out_status;
    logic signed [SAMPLE_W-1:0] r_rdata;
    logic [SAMPLE_W-1:0]        r_grid [DEPTH];

    logic                       out_free;
    logic                       pop;
    logic                       mem_we;
    logic [AW-1:0]              wr_addr;
    logic [AW-1:0]              rd_addr;
    logic                       step_last;
    logic [1:0]                 far;
    logic signed [ACC_W-1:0]    term;

    always_comb begin
        out_free    = !r_out_valid || i_ready;
        // Writes never touch the result register, so only results wait on it.
        o_cmd_ready = (r_state == ST_IDLE) && ((i_kind == KIND_WRITE) || out_free);
        pop         = i_cmd_valid && o_cmd_ready;
        mem_we      = pop && (i_kind == KIND_WRITE);
        wr_addr     = cell_addr(i_x, i_y, i_z);
        rd_addr     = cell_addr(r_cx + CW'(r_dx) - CW'(1), r_cy + CW'(r_dy) - CW'(1),
                                r_cz + CW'(r_dz) - CW'(1));
        step_last   = (r_dx == TAP_HI) && (r_dy == TAP_HI) && (r_dz == TAP_HI);
        // Weight is 8 >> (number of offset axes), applied as a left shift.
        far         = 2'(r_dx != TAP_MID) + 2'(r_dy != TAP_MID) + 2'(r_dz != TAP_MID);
        term        = ACC_W'(r_rdata) <<< r_rd_sh;
    end

    always_comb begin
        n_state      = r_state;
        n_cx         = r_cx;
        n_cy         = r_cy;
        n_cz         = r_cz;
        n_dx         = r_dx;
        n_dy         = r_dy;
        n_dz         = r_dz;
        n_rd_valid   = 1'b0;
        n_rd_sh      = r_rd_sh;
        n_acc        = r_acc;
        n_out_valid  = r_out_valid;
        n_out_value  = r_out_value;
        n_out_status = r_out_status;
        if (r_out_valid && i_ready) begin
            n_out_valid = 1'b0;
        end
        if (r_rd_valid) begin
            n_acc = r_acc + term;
        end
        unique case (r_state)
            ST_IDLE: begin
                if (pop) begin
                    unique case (i_kind)
                        KIND_COMPUTE: begin
                            n_cx    = i_x;
                            n_cy    = i_y;
                            n_cz    = i_z;
                            n_dx    = TAP_LO;
                            n_dy    = TAP_LO;
                            n_dz    = TAP_LO;
                            n_acc   = '0;
                            n_state = ST_RUN;
                        end
                        KIND_ERROR: begin
                            n_out_valid  = 1'b1;
                            n_out_value  = '0;
                            n_out_status = STATUS_ERR;
                        end
                        default: begin
                            // A write goes straight to the memory port.
                            n_state = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_RUN: begin
                n_rd_valid = 1'b1;
                n_rd_sh    = SH_CENTER - far;
                if (r_dz == TAP_HI) begin
                    n_dz = TAP_LO;
                    if (r_dy == TAP_HI) begin
                        n_dy = TAP_LO;
                        n_dx = r_dx + 1'b1;
                    end else begin
                        n_dy = r_dy + 1'b1;
                    end
                end else begin
                    n_dz = r_dz + 1'b1;
                end
                if (step_last) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                n_state = ST_OUT;
            end
            ST_OUT: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_value  = r_acc[ACC_W-1:AVG_SHIFT];
                    n_out_status = STATUS_OK;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_rd_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_rd_valid  <= n_rd_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cx         <= n_cx;
        r_cy         <= n_cy;
        r_cz         <= n_cz;
        r_dx         <= n_dx;
        r_dy         <= n_dy;
        r_dz         <= n_dz;
        r_rd_sh      <= n_rd_sh;
        r_acc        <= n_acc;
        r_out_value  <= n_out_value;
        r_out_status <= n_out_status;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_grid[wr_addr] <= i_sample;
        end
        r_rdata <= signed'(r_grid[rd_addr]);
    end

    assign o_valid  = r_out_valid;
    assign o_value  = r_out_value;
    assign o_status = r_out_status;

    `ASSERT_PROP(a_read_from_run, i_clk, i_rst_n,
        r_rd_valid |-> ($past(r_state) == ST_RUN),
        "stencil read data without a read issued by the sequencer")
    `ASSERT_NEVER(a_out_after_drain, i_clk, i_rst_n,
        (r_state == ST_OUT) && r_rd_valid,
        "result taken while a stencil tap is still in flight")

endmodule

`default_nettype wire
